FILE: hw/rtl/rgbcf_pkg.sv
// Package for the RGB 3x3 convolution filter.
// It holds the shared constants, payload structs and state encodings.
// It depends on nothing else.
package rgbcf_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int KernelSize = 3;
  localparam int Taps       = KernelSize * KernelSize;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int DimW       = 11;
  localparam int RowW       = $clog2(MaxHeight) + 2;
  localparam int OutIdxW    = $clog2(MaxWidth) + $clog2(MaxHeight);
  localparam int TapW       = $clog2(Taps);
  localparam int SumW       = 20;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 24;
  localparam logic [7:0] PixMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_TOP    = 3'd0,
    CFG_COEF_MIDDLE = 3'd1,
    CFG_COEF_BOTTOM = 3'd2,
    CFG_DIVISOR     = 3'd3,
    CFG_WIDTH       = 3'd4,
    CFG_HEIGHT      = 3'd5
  } cfg_idx_e;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_padding;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } res_t;

  typedef struct packed {
    rgb_t [Taps-1:0] tap;
    logic [Taps-1:0] mask;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } geom_t;

  typedef struct packed {
    logic [Taps-1:0][7:0] coef;
    logic [7:0]           div;
  } kern_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_STEP = 2'b10
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MAC  = 4'b0010,
    B_DIV  = 4'b0100,
    B_DONE = 4'b1000
  } back_state_e;

endpackage

FILE: hw/rtl/rgbcf_front.sv
// Front end of the filter: line stores, window registers and position counters.
// It builds one tap job per output pixel. It depends on rgbcf_pkg.
module rgbcf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rgbcf_pkg::geom_t    geom_i,
  input  logic                restart_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rgbcf_pkg::pix_t     in_data_i,
  output logic                push_o,
  output rgbcf_pkg::job_t     job_o,
  input  logic                full_i
);
  import rgbcf_pkg::*;

  front_state_e state_q, state_d;
  logic [ColW-1:0] col_q, col_eff, addr_q, co;
  logic [RowW-1:0] row_q;
  logic [OutIdxW-1:0] oidx_q;
  rgb_t near_mem [MaxWidth];
  rgb_t far_mem [MaxWidth];
  rgb_t px_q, near_rd_q, far_rd_q;
  rgb_t [KernelSize-1:0][KernelSize-1:0] win_q, win_d;
  rgb_t [KernelSize-1:0] rows;
  logic signed [RowW+1:0] ro, row_s;
  logic signed [RowW+1:0] ir [KernelSize];
  logic [KernelSize-1:0] rowv, colv;
  logic [2*DimW-1:0] area;
  logic [DimW-1:0] col_inc;
  logic accept, step, ok, last, wrap;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept = in_valid_i && (state_q == F_IDLE);
  assign col_eff = ({1'b0, col_q} >= geom_i.width) ? '0 : col_q;

  assign row_s = $signed({2'b00, row_q});
  assign ro = (col_eff != '0) ? row_s - 14'sd1 : row_s - 14'sd2;
  assign co = (col_eff != '0) ? col_eff - 1'b1 : ColW'(geom_i.width - 1'b1);
  assign ok = !ro[RowW+1];

  always_comb begin
    for (int kr = 0; kr < KernelSize; kr++) begin
      ir[kr] = ro + $signed((RowW+2)'(kr)) - 14'sd1;
      rowv[kr] = !ir[kr][RowW+1] && (ir[kr] < $signed({3'b000, geom_i.height}));
    end
  end

  assign colv[0] = (co != '0);
  assign colv[1] = 1'b1;
  assign colv[2] = ((DimW'(co) + 11'd1) < geom_i.width);

  assign area = geom_i.width * geom_i.height;
  assign last = ({2'b00, oidx_q} == (area - 22'd1));

  assign col_inc = {1'b0, col_eff} + 11'd1;
  assign wrap = (col_inc >= geom_i.width);

  assign step = (state_q == F_STEP) && !(ok && full_i);
  assign push_o = step && ok;

  assign rows[0] = far_rd_q;
  assign rows[1] = near_rd_q;
  assign rows[2] = px_q;

  always_comb begin
    for (int r = 0; r < KernelSize; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
      win_d[r][2] = rows[r];
    end
    for (int r = 0; r < KernelSize; r++) begin
      for (int c = 0; c < KernelSize; c++) begin
        job_o.tap[r*KernelSize+c]  = win_d[r][c];
        job_o.mask[r*KernelSize+c] = rowv[r] & colv[c];
      end
    end
    job_o.last = last;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_STEP;
      end
      F_STEP: begin
        if (step) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      near_rd_q <= near_mem[col_eff];
      far_rd_q  <= far_mem[col_eff];
      px_q      <= in_data_i.is_padding ? '0
                   : {in_data_i.blue, in_data_i.green, in_data_i.red};
      addr_q    <= col_eff;
    end
    if (step) begin
      far_mem[addr_q]  <= near_rd_q;
      near_mem[addr_q] <= px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      oidx_q  <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      if (step) win_q <= win_d;
      if (restart_i) begin
        col_q  <= '0;
        row_q  <= '0;
        oidx_q <= '0;
      end else if (step) begin
        if (ok && last) begin
          col_q  <= '0;
          row_q  <= '0;
          oidx_q <= '0;
        end else begin
          col_q <= wrap ? '0 : col_inc[ColW-1:0];
          row_q <= wrap ? row_q + 1'b1 : row_q;
          if (ok) oidx_q <= oidx_q + 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/rgbcf_queue.sv
// Short job queue between the front end and the arithmetic back end.
// It depends on rgbcf_pkg.
module rgbcf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rgbcf_pkg::job_t job_i,
  output logic            full_o,
  output logic            avail_o,
  input  logic            pop_i,
  output rgbcf_pkg::job_t job_o
);
  import rgbcf_pkg::*;

  job_t mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0] cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/rgbcf_back.sv
// Back end of the filter: tap-serial multiply-accumulate, bit-serial divide, clamp.
// It holds the result register. It depends on rgbcf_pkg.
module rgbcf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rgbcf_pkg::kern_t kern_i,
  input  logic            avail_i,
  input  rgbcf_pkg::job_t job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rgbcf_pkg::res_t out_data_o
);
  import rgbcf_pkg::*;

  back_state_e state_q;
  job_t job_q;
  logic [TapW-1:0] t_q;
  logic [2:0] i_q;
  logic signed [SumW-1:0] sum_q [3];
  logic signed [SumW-1:0] sum_d [3];
  logic [SumW-2:0] rem_q [3];
  logic [7:0] quo_q [3];
  logic [7:0] fin [3];
  logic signed [16:0] prod [3];
  logic [SumW-2:0] dsh;
  rgb_t pix;
  res_t out_q;
  logic out_valid_q, load, taken;

  assign pop_o = (state_q == B_IDLE) && avail_i;
  assign pix = job_q.tap[t_q];
  assign dsh = (SumW-1)'(kern_i.div) << i_q;
  assign load = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);
  assign taken = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = $signed(kern_i.coef[t_q]) * $signed({1'b0, pix[8*ch+:8]});
      sum_d[ch] = job_q.mask[t_q] ? sum_q[ch] + SumW'(prod[ch]) : sum_q[ch];
      if (sum_q[ch][SumW-1] || (sum_q[ch] == '0)) begin
        fin[ch] = '0;
      end else if (sum_q[ch] >= $signed({4'b0000, kern_i.div, 8'h00})) begin
        fin[ch] = PixMax;
      end else begin
        fin[ch] = quo_q[ch];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (load) out_q <= '{out_red: fin[0], out_green: fin[1], out_blue: fin[2],
                         frame_last: job_q.last};
    case (state_q)
      B_IDLE: begin
        for (int ch = 0; ch < 3; ch++) sum_q[ch] <= '0;
      end
      B_MAC: begin
        for (int ch = 0; ch < 3; ch++) begin
          sum_q[ch] <= sum_d[ch];
          rem_q[ch] <= sum_d[ch][SumW-2:0];
          quo_q[ch] <= '0;
        end
      end
      B_DIV: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (rem_q[ch] >= dsh) begin
            rem_q[ch] <= rem_q[ch] - dsh;
            quo_q[ch][i_q] <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      t_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) out_valid_q <= 1'b1;
      else if (taken) out_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          t_q <= '0;
          if (avail_i) state_q <= B_MAC;
        end
        B_MAC: begin
          t_q <= t_q + 1'b1;
          if (t_q == TapW'(Taps - 1)) begin
            i_q <= 3'd7;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          i_q <= i_q - 1'b1;
          if (i_q == '0) state_q <= B_DONE;
        end
        B_DONE: begin
          if (load) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rgb_conv3x3_filter.sv
// Top level of the RGB 3x3 convolution filter: configuration registers and wiring.
// It depends on rgbcf_pkg, rgbcf_front, rgbcf_queue and rgbcf_back.
//
//   channel  signals                                   direction
//   in       in_valid_i, in_stall_o, in_data_i         pixel requests in
//   out      out_valid_o, out_stall_i, out_data_o      filtered pixels out
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i         register writes in
//
// The front end takes no new request until the last one is in the line stores.
// The back end works through nine multiply-accumulate steps over the taps
// and eight divide steps, then the load of the result register.
// Requests without a result pass through the front end only.
// Reset restores the register defaults; line store contents stay unknown.
// A stalled output fills the queue, and then the input stalls.
module rgb_conv3x3_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rgbcf_pkg::pix_t                   in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rgbcf_pkg::res_t                   out_data_o,
  input  logic                              cfg_we_i,
  input  logic [rgbcf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rgbcf_pkg::CfgDataW-1:0]    cfg_data_i
);
  import rgbcf_pkg::*;

  logic [KernelSize-1:0][23:0] coef_q;
  logic [7:0] div_q;
  logic [DimW-1:0] width_q, height_q;
  geom_t geom;
  kern_t kern;
  job_t job_in, job_out;
  logic restart, push, full, avail, pop;

  assign restart = cfg_we_i && ((cfg_index_i == CFG_WIDTH) || (cfg_index_i == CFG_HEIGHT));

  always_comb begin
    geom.width = (width_q == '0) ? DimW'(1)
                 : (width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
    geom.height = (height_q == '0) ? DimW'(1)
                  : (height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;
    for (int r = 0; r < KernelSize; r++) begin
      for (int c = 0; c < KernelSize; c++) begin
        kern.coef[r*KernelSize+c] = coef_q[r][8*c+:8];
      end
    end
    kern.div = (div_q == '0) ? 8'd1 : div_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= 24'd0;
      coef_q[1] <= 24'd256;
      coef_q[2] <= 24'd0;
      div_q     <= 8'd1;
      width_q   <= 11'd512;
      height_q  <= 11'd512;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COEF_TOP:    coef_q[0] <= cfg_data_i;
        CFG_COEF_MIDDLE: coef_q[1] <= cfg_data_i;
        CFG_COEF_BOTTOM: coef_q[2] <= cfg_data_i;
        CFG_DIVISOR:     div_q <= cfg_data_i[7:0];
        CFG_WIDTH:       width_q <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT:      height_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  rgbcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom),
    .restart_i  (restart),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  rgbcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .avail_o (avail),
    .pop_i   (pop),
    .job_o   (job_out)
  );

  rgbcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kern_i      (kern),
    .avail_i     (avail),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/rgbcf_result_checker.sv
// Checker for the RGB 3x3 convolution filter: watches the request, result and register channels.
// It predicts every filtered pixel and compares the results in order.
// It depends on rgbcf_pkg.
`timescale 1ns / 1ps

module rgbcf_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  rgbcf_pkg::pix_t                in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  rgbcf_pkg::res_t                out_data_i,
  input  logic                           cfg_we_i,
  input  logic [rgbcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rgbcf_pkg::CfgDataW-1:0] cfg_data_i,
  output int                             fail_cnt_o,
  output int                             pend_cnt_o
);
  import rgbcf_pkg::*;

  logic [23:0]     kern_row [3];
  logic [7:0]      kern_div;
  logic [DimW-1:0] geo_w;
  logic [DimW-1:0] geo_h;
  rgb_t            near_row [MaxWidth];
  rgb_t            far_row  [MaxWidth];
  rgb_t            win      [3][3];
  int              col_pos;
  int              row_pos;
  int              pix_idx;
  res_t            filtered_q[$];

  function automatic int dim_of(logic [DimW-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic [7:0] clamp_px(int s, int dv);
    int q;
    q = s / dv;
    if (q > 255) q = 255;
    if (q < 0) q = 0;
    return q[7:0];
  endfunction

  task automatic filter_pixel(pix_t p);
    int   w, h, col, ro, co, ir, ic, cf, dv;
    int   sum [3];
    rgb_t px, top, mid;
    rgb_t rows [3];
    res_t r;
    w   = dim_of(geo_w, MaxWidth);
    h   = dim_of(geo_h, MaxHeight);
    dv  = (kern_div == 0) ? 1 : int'(kern_div);
    col = (col_pos >= w) ? 0 : col_pos;
    px  = p.is_padding ? '0 : {p.blue, p.green, p.red};
    top = far_row[col];
    mid = near_row[col];
    far_row[col]  = mid;
    near_row[col] = px;
    rows[0] = top;
    rows[1] = mid;
    rows[2] = px;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
      win[i][2] = rows[i];
    end
    if (col >= 1) begin
      ro = row_pos - 1;
      co = col - 1;
    end else begin
      ro = row_pos - 2;
      co = w - 1;
    end
    col++;
    if (col >= w) begin
      col = 0;
      row_pos++;
    end
    col_pos = col;
    if (ro < 0 || pix_idx >= w * h) return;
    sum = '{0, 0, 0};
    for (int kr = 0; kr < 3; kr++) begin
      ir = ro + kr - 1;
      if (ir < 0 || ir >= h) continue;
      for (int kc = 0; kc < 3; kc++) begin
        ic = co + kc - 1;
        if (ic < 0 || ic >= w) continue;
        cf = int'($signed(kern_row[kr][8*kc +: 8]));
        for (int ch = 0; ch < 3; ch++) sum[ch] += cf * int'(win[kr][kc][8*ch +: 8]);
      end
    end
    r.out_red    = clamp_px(sum[0], dv);
    r.out_green  = clamp_px(sum[1], dv);
    r.out_blue   = clamp_px(sum[2], dv);
    r.frame_last = (pix_idx == w * h - 1);
    pix_idx++;
    if (r.frame_last) begin
      col_pos = 0;
      row_pos = 0;
      pix_idx = 0;
    end
    filtered_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      kern_row[0] = '0;
      kern_row[1] = 24'd256;
      kern_row[2] = '0;
      kern_div    = 8'd1;
      geo_w       = 11'd512;
      geo_h       = 11'd512;
      for (int i = 0; i < MaxWidth; i++) begin
        near_row[i] = '0;
        far_row[i]  = '0;
      end
      win        = '{default: '0};
      col_pos    = 0;
      row_pos    = 0;
      pix_idx    = 0;
      fail_cnt_o = 0;
      filtered_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_COEF_TOP:    kern_row[0] = cfg_data_i;
          CFG_COEF_MIDDLE: kern_row[1] = cfg_data_i;
          CFG_COEF_BOTTOM: kern_row[2] = cfg_data_i;
          CFG_DIVISOR:     kern_div    = cfg_data_i[7:0];
          CFG_WIDTH, CFG_HEIGHT: begin
            if (cfg_idx_e'(cfg_index_i) == CFG_WIDTH) geo_w = cfg_data_i[DimW-1:0];
            else geo_h = cfg_data_i[DimW-1:0];
            col_pos = 0;
            row_pos = 0;
            pix_idx = 0;
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          $error("result without a pending request: %p", out_data_i);
          fail_cnt_o++;
        end else begin
          want = filtered_q.pop_front();
          if (out_data_i.out_red !== want.out_red) begin
            $error("out_red expected %0d actual %0d", want.out_red, out_data_i.out_red);
            fail_cnt_o++;
          end
          if (out_data_i.out_green !== want.out_green) begin
            $error("out_green expected %0d actual %0d", want.out_green, out_data_i.out_green);
            fail_cnt_o++;
          end
          if (out_data_i.out_blue !== want.out_blue) begin
            $error("out_blue expected %0d actual %0d", want.out_blue, out_data_i.out_blue);
            fail_cnt_o++;
          end
          if (out_data_i.frame_last !== want.frame_last) begin
            $error("frame_last expected %0b actual %0b", want.frame_last,
                   out_data_i.frame_last);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) filter_pixel(in_data_i);
    end
    pend_cnt_o = filtered_q.size();
  end

endmodule

FILE: tb/sv/rgb_conv3x3_filter_tb.sv
// Testbench top for the RGB 3x3 convolution filter: clock, reset, stimulus and verdict.
// It depends on rgbcf_pkg, rgb_conv3x3_filter and rgbcf_result_checker.
`timescale 1ns / 1ps

module rgb_conv3x3_filter_tb;
  import rgbcf_pkg::*;

  localparam int IdleLimit = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pix_t                in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  res_t                out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  fail_cnt;
  int                  pend_cnt;
  int                  sent = 0;
  int                  stuck = 0;
  bit                  send_gaps = 1'b1;
  bit                  recv_gaps = 1'b1;
  bit                  hold_go = 1'b0;
  bit                  hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  rgb_conv3x3_filter dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  rgbcf_result_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .fail_cnt_o(fail_cnt), .pend_cnt_o(pend_cnt)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_stall_i <= recv_gaps && ($urandom_range(99) < 36);
      end
    end
  end

  task automatic send_pix(pix_t p);
    while (send_gaps && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic cfg_wr(cfg_idx_e idx, logic [CfgDataW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(negedge clk_i);
  endtask

  task automatic program_all(logic [23:0] t, logic [23:0] m, logic [23:0] b,
                             logic [7:0] dv, logic [10:0] w, logic [10:0] h);
    cfg_wr(CFG_COEF_TOP, t);
    cfg_wr(CFG_COEF_MIDDLE, m);
    cfg_wr(CFG_COEF_BOTTOM, b);
    cfg_wr(CFG_DIVISOR, {16'd0, dv});
    cfg_wr(CFG_WIDTH, {13'd0, w});
    cfg_wr(CFG_HEIGHT, {13'd0, h});
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // A frame of w by h pixels followed by its drain slots; cut stops it early.
  task automatic send_frame(logic [10:0] wr, logic [10:0] hr, int cut);
    int   w, h, n;
    pix_t p;
    w = (wr == 0) ? 1 : (wr > MaxWidth) ? MaxWidth : int'(wr);
    h = (hr == 0) ? 1 : (hr > MaxHeight) ? MaxHeight : int'(hr);
    n = 0;
    for (int i = 0; i < w * h + w + 1 && n < cut; i++) begin
      p = pix_t'($urandom);
      case ($urandom_range(3))
        0: {p.red, p.green, p.blue} = '0;
        1: {p.red, p.green, p.blue} = '1;
        default: ;
      endcase
      if (i < w * h) p.is_padding = ($urandom_range(19) == 0);
      else p.is_padding = ($urandom_range(7) != 0);
      send_pix(p);
      n++;
    end
    wait_idle();
  endtask

  function automatic logic [23:0] rand_row(bit mild);
    logic [23:0] r;
    r = 24'($urandom);
    if (mild) for (int k = 0; k < 3; k++) r[8*k +: 8] = 8'($signed($urandom_range(8)) - 4);
    return r;
  endfunction

  initial begin
    logic [10:0] w, h;
    bit          mild;
    int          phase;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    program_all(24'h0, 24'h000100, 24'h0, 8'd1, 11'd3, 11'd3);
    send_frame(11'd3, 11'd3, 1 << 30);
    program_all(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd0, 11'd2, 11'd2);
    send_frame(11'd2, 11'd2, 1 << 30);
    program_all(24'h808080, 24'h808080, 24'h808080, 8'd255, 11'd4, 11'd1);
    send_frame(11'd4, 11'd1, 1 << 30);
    program_all(24'h010203, 24'hFF01FE, 24'h030201, 8'd2, 11'd0, 11'd0);
    send_frame(11'd0, 11'd0, 1 << 30);

    phase = 0;
    while (sent < 230 || phase < 5) begin
      send_gaps = (phase % 5 != 2);
      recv_gaps = (phase % 5 != 2);
      mild = 1'($urandom_range(1));
      w = 11'($urandom_range(1, 8));
      h = 11'($urandom_range(1, 6));
      if ($urandom_range(9) == 0) w = $urandom_range(1) ? 11'd0 : 11'd12;
      if ($urandom_range(9) == 0) h = $urandom_range(1) ? 11'd0 : 11'd10;
      if (phase == 3) begin
        w = 11'd16;
        h = 11'd8;
      end
      program_all(rand_row(mild), rand_row(mild), rand_row(mild),
                  mild ? 8'($urandom_range(16)) : 8'($urandom), w, h);
      if (phase == 3) hold_go = 1'b1;
      send_frame(w, h, ($urandom_range(9) == 0) ? int'($urandom_range(1, 20)) : (1 << 30));
      phase++;
    end

    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    program_all(rand_row(1'b1), rand_row(1'b1), rand_row(1'b1), 8'd3, 11'd2047, 11'd1);
    send_frame(11'd2047, 11'd1, 40);
    program_all(rand_row(1'b1), rand_row(1'b1), rand_row(1'b1), 8'd1, 11'd1, 11'd2047);
    send_frame(11'd1, 11'd2047, 1 << 30);

    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
